FILE: sv/ldf_pkg.sv
// Package for the length prefix deframer: codes, constants and queue entry type.
package ldf_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 15;
  localparam int unsigned HIGH_W      = 7;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] SHORT_LIMIT_B = 8'd160;
  localparam logic [LEN_W-1:0]  SHORT_LIMIT_L = 15'd160;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LOW    = 2'd1,
    PH_HELD   = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  // pair: emit data (not last), then held as the last byte with len
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] held;
    logic              last;
    logic              pair;
    logic [LEN_W-1:0]  len;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: sv/ldf_if.sv
// Stream interfaces of the deframer: link byte channel and payload channel.
interface ldf_link_if;
  logic                        valid;
  logic                        ready;
  logic [ldf_pkg::BYTE_W-1:0]  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface ldf_payload_if;
  logic                        valid;
  logic                        ready;
  logic [ldf_pkg::BYTE_W-1:0]  payload_byte;
  logic                        last_of_packet;
  logic [ldf_pkg::LEN_W-1:0]   packet_length;

  modport source (output valid, output payload_byte, output last_of_packet,
                  output packet_length, input ready);
  modport sink   (input valid, input payload_byte, input last_of_packet,
                  input packet_length, output ready);
endinterface

FILE: sv/ldf_front.sv
// Front part: header parsing and packet state, turns payload bytes into queue entries.
module ldf_front (
  input  logic                  clk,
  input  logic                  rst,
  ldf_link_if.sink              link,
  input  ldf_pkg::queue_status_t qstat,
  output logic                  push,
  output ldf_pkg::entry_t       push_data
);

  ldf_pkg::phase_t              phase, phase_next;
  logic [ldf_pkg::HIGH_W-1:0]   header_high, header_high_next;
  logic [ldf_pkg::LEN_W-1:0]    remaining, remaining_next;
  logic [ldf_pkg::LEN_W-1:0]    total_length, total_length_next;
  logic [ldf_pkg::BYTE_W-1:0]   held_final_byte, held_final_byte_next;
  logic [ldf_pkg::LEN_W-1:0]    new_len;
  logic [ldf_pkg::BYTE_W-1:0]   b;
  logic [ldf_pkg::BYTE_W-1:0]   high_diff;
  logic                         accept;
  logic                         emit;

  assign link.ready = !qstat.full;
  assign accept     = link.valid && link.ready;
  assign push       = accept && emit;
  assign b          = link.in_byte;
  assign high_diff  = b - ldf_pkg::SHORT_LIMIT_B;

  always_comb begin
    phase_next           = phase;
    header_high_next     = header_high;
    remaining_next       = remaining;
    total_length_next    = total_length;
    held_final_byte_next = held_final_byte;
    emit                 = 1'b0;
    push_data            = '{data: b, held: held_final_byte, last: 1'b0, pair: 1'b0,
                             len: '0};
    new_len              = '0;
    case (phase)
      ldf_pkg::PH_HEADER, ldf_pkg::PH_LOW: begin
        if (phase == ldf_pkg::PH_HEADER && b >= ldf_pkg::SHORT_LIMIT_B) begin
          header_high_next = high_diff[ldf_pkg::HIGH_W-1:0];
          phase_next       = ldf_pkg::PH_LOW;
        end else begin
          if (phase == ldf_pkg::PH_HEADER) begin
            new_len = {{(ldf_pkg::LEN_W-ldf_pkg::BYTE_W){1'b0}}, b};
          end else begin
            new_len = {header_high, b};
          end
          total_length_next = new_len;
          if (new_len == '0) begin
            phase_next = ldf_pkg::PH_HEADER;
          end else if (new_len < ldf_pkg::SHORT_LIMIT_L) begin
            phase_next = ldf_pkg::PH_HELD;
          end else begin
            remaining_next = new_len;
            phase_next     = ldf_pkg::PH_BODY;
          end
        end
      end
      ldf_pkg::PH_HELD: begin
        held_final_byte_next = b;
        if (total_length <= ldf_pkg::LEN_W'(1)) begin
          emit           = 1'b1;
          push_data.last = 1'b1;
          push_data.len  = total_length;
          phase_next     = ldf_pkg::PH_HEADER;
        end else begin
          remaining_next = total_length - ldf_pkg::LEN_W'(1);
          phase_next     = ldf_pkg::PH_BODY;
        end
      end
      default: begin
        emit = 1'b1;
        if (remaining > ldf_pkg::LEN_W'(1)) begin
          remaining_next = remaining - ldf_pkg::LEN_W'(1);
        end else begin
          remaining_next = '0;
          phase_next     = ldf_pkg::PH_HEADER;
          push_data.len  = total_length;
          if (total_length < ldf_pkg::SHORT_LIMIT_L) begin
            push_data.pair = 1'b1;
          end else begin
            push_data.last = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ldf_pkg::PH_HEADER;
      header_high     <= '0;
      remaining       <= '0;
      total_length    <= '0;
      held_final_byte <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      header_high     <= header_high_next;
      remaining       <= remaining_next;
      total_length    <= total_length_next;
      held_final_byte <= held_final_byte_next;
    end
  end

  a_body_remaining: assert property (@(posedge clk) disable iff (rst)
    phase == ldf_pkg::PH_BODY |-> remaining != '0)
    else $error("body phase with nothing remaining");

  a_held_short: assert property (@(posedge clk) disable iff (rst)
    phase == ldf_pkg::PH_HELD |-> total_length != '0 && total_length < ldf_pkg::SHORT_LIMIT_L)
    else $error("held phase with a length that is not short");

endmodule

FILE: sv/ldf_queue.sv
// Short queue of classified entries between the front and back parts.
module ldf_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ldf_pkg::entry_t        push_data,
  input  logic                   pop,
  output ldf_pkg::entry_t        head,
  output ldf_pkg::queue_status_t qstat
);

  ldf_pkg::entry_t              slots [ldf_pkg::QUEUE_DEPTH];
  logic [ldf_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ldf_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ldf_pkg::QCNT_W-1:0]   count;

  assign qstat.full  = count == ldf_pkg::QCNT_W'(ldf_pkg::QUEUE_DEPTH);
  assign qstat.empty = count == '0;
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + ldf_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + ldf_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + ldf_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - ldf_pkg::QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && qstat.empty))
    else $error("queue pop while empty");

endmodule

FILE: sv/ldf_back.sv
// Back part: drains queue entries into the payload output register.
module ldf_back (
  input  logic                   clk,
  input  logic                   rst,
  input  ldf_pkg::entry_t        head,
  input  ldf_pkg::queue_status_t qstat,
  output logic                   pop,
  ldf_payload_if.source          payload
);

  logic                         out_valid;
  logic [ldf_pkg::BYTE_W-1:0]   out_byte;
  logic                         out_last;
  logic [ldf_pkg::LEN_W-1:0]    out_len;
  logic                         pend;
  logic [ldf_pkg::BYTE_W-1:0]   pend_byte;
  logic [ldf_pkg::LEN_W-1:0]    pend_len;
  logic                         load;

  assign load = !out_valid || payload.ready;
  assign pop  = load && !pend && !qstat.empty;

  assign payload.valid          = out_valid;
  assign payload.payload_byte   = out_byte;
  assign payload.last_of_packet = out_last;
  assign payload.packet_length  = out_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (!qstat.empty) begin
        out_valid <= 1'b1;
        pend      <= head.pair;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        out_byte <= pend_byte;
        out_last <= 1'b1;
        out_len  <= pend_len;
      end else if (!qstat.empty) begin
        out_byte <= head.data;
        if (head.pair) begin
          out_last  <= 1'b0;
          out_len   <= '0;
          pend_byte <= head.held;
          pend_len  <= head.len;
        end else begin
          out_last <= head.last;
          out_len  <= head.len;
        end
      end
    end
  end

  a_pend_first_half: assert property (@(posedge clk) disable iff (rst)
    pend |-> out_valid && !out_last)
    else $error("held byte pending without the first half on the output");

endmodule

FILE: sv/length_prefix_deframer_unit.sv
// Top level of the length prefix deframer.
// Usage:
//   link    : link bytes in, one request per byte (valid/ready, in_byte).
//   payload : payload bytes out with last_of_packet and packet_length, the
//             length being nonzero only on the last byte of a packet.
// A header byte below 160 is the length; 160 or more starts a two-byte
// header. Zero lengths are dropped. For short packets the first body byte
// is held and delivered last.
// Path: a taken byte is written into the queue, then loaded from its head into
// the payload output register; the held byte follows from a pending register.
// Throughput: one byte per cycle in and out while link.ready and payload.ready
// are high. The end of a short packet yields two results from one byte; the
// back part delivers them in turn and the four-entry queue absorbs the difference.
// Stalls: when payload.ready is low the output register holds; the queue
// fills and link.ready drops only when all four entries are taken.
// Reset: synchronous, clears the header parser, the queue and the valid and
// pending flags of the output stage; the first byte after reset is a header.
module length_prefix_deframer_unit (
  input  logic         clk,
  input  logic         rst,
  ldf_link_if.sink     link,
  ldf_payload_if.source payload
);

  logic                   push;
  logic                   pop;
  ldf_pkg::entry_t        push_data;
  ldf_pkg::entry_t        head;
  ldf_pkg::queue_status_t qstat;

  ldf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .link      (link),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  ldf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  ldf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .qstat   (qstat),
    .pop     (pop),
    .payload (payload)
  );

endmodule
